### design/vff_pkg.sv
package vff_pkg;

    localparam int DefLengthBits = 24;
    localparam int FrameLenBits  = 24;
    localparam int HdrBytes      = 6;
    localparam int QueueDepth    = 4;

    localparam logic [15:0] MaxPayloadReset  = 16'd1434;
    localparam logic [23:0] StreamIdentReset = 24'h00dede;

    // Configuration register indexes
    localparam logic CfgMaxPayload  = 1'b0;
    localparam logic CfgStreamIdent = 1'b1;

    // Fragment types
    localparam logic [1:0] FtWhole = 2'd0;
    localparam logic [1:0] FtStart = 2'd1;
    localparam logic [1:0] FtCont  = 2'd2;
    localparam logic [1:0] FtEnd   = 2'd3;

    localparam logic [3:0] PacketCount = 4'd1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [23:0] frame_length;
        logic [1:0]  data_type;
        logic [31:0] frame_timestamp;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_header;
        logic        packet_end;
        logic [31:0] packet_timestamp;
        logic        run_last;
    } out_item_t;

    // One classified input byte, as handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        need_hdr;
        logic [1:0]  frag_type;
        logic [1:0]  data_type;
        logic [15:0] frag_len;
        logic        packet_end;
        logic [31:0] timestamp;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_HEAD0,
        BK_HEAD1,
        BK_HEAD2,
        BK_HEAD3,
        BK_HEAD4,
        BK_HEAD5,
        BK_DATA
    } back_state_t;

endpackage

### design/video_frame_fragmenter_core.sv
// Frame fragmenter: cuts a coded frame, fed one byte per word on the input
// channel, into packets of at most max_payload payload bytes. Each packet
// goes out as a 6-byte header (ident, fragment type, data type, count,
// then the big-endian payload length) followed by its payload words.
// The first word of a frame carries frame_length, data_type and
// frame_timestamp; later words of the frame only data_byte.
// Configuration: cfg index 0 is max_payload, index 1 is stream_ident;
// write them only while the block is idle. cfg_ready is always high.
// A payload word passes through the queue and the output register after
// its input word is accepted, behind six header words when it opens a
// packet. One word per cycle is sustained on both sides while out_ready
// is high and no header is due; the input stalls once the four-entry
// queue between the classifier and the output sequencer fills.
// Reset clears the open frame, the queue, the output valid flag and the header state.
// When out_ready is low the output word holds and the queue absorbs up
// to four further input words before in_ready drops.
module video_frame_fragmenter_core #(
    parameter int LENGTH_BITS = vff_pkg::DefLengthBits
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vff_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vff_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data
);
    import vff_pkg::*;

    logic [15:0] max_payload_reg;
    logic [23:0] stream_ident_reg;
    logic        q_full;
    logic        push;
    cmd_t        push_data;
    logic        pop;
    cmd_t        head;
    logic        head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= MaxPayloadReset;
            stream_ident_reg <= StreamIdentReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgMaxPayload:  max_payload_reg  <= cfg_data[15:0];
                CfgStreamIdent: stream_ident_reg <= cfg_data;
                default:        max_payload_reg  <= max_payload_reg;
            endcase
        end
    end

    vff_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .max_payload (max_payload_reg),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    vff_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    vff_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .stream_ident (stream_ident_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

### design/vff_queue.sv
module vff_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vff_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output vff_pkg::cmd_t head,
    output logic          head_valid
);
    import vff_pkg::*;

    localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntBits = $clog2(QueueDepth + 1);

    cmd_t                 mem_reg [QueueDepth];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   wr_ptr_next;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_next;
    logic [CntBits-1:0]   count_reg;
    logic [CntBits-1:0]   count_next;

    assign full       = (count_reg == CntBits'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntBits'(QueueDepth))
        else $error("queue count beyond depth");

endmodule

### design/vff_front.sv
module vff_front #(
    parameter int LENGTH_BITS = vff_pkg::DefLengthBits
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  vff_pkg::in_item_t in_data,
    input  logic [15:0]      max_payload,
    input  logic             q_full,
    output logic             push,
    output vff_pkg::cmd_t    push_data
);
    import vff_pkg::*;

    localparam int FlBits = (LENGTH_BITS < FrameLenBits) ? LENGTH_BITS : FrameLenBits;

    logic [FlBits-1:0] frame_left_reg;
    logic [FlBits-1:0] frame_left_next;
    logic [15:0]       frag_left_reg;
    logic [15:0]       frag_left_next;
    logic              later_reg;
    logic              later_next;
    logic [1:0]        type_reg;
    logic [1:0]        type_next;
    logic [31:0]       ts_reg;
    logic [31:0]       ts_next;

    logic              first;
    logic [FlBits-1:0] fl;
    logic [FlBits-1:0] fl_dec;
    logic [15:0]       fr;
    logic [15:0]       fr_new;
    logic              lf;
    logic [15:0]       mtu;
    logic              last;
    logic              need_hdr;
    logic [15:0]       len;
    logic [1:0]        ft;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        first = (frame_left_reg == '0);
        fl    = first ? in_data.frame_length[FlBits-1:0] : frame_left_reg;
        // A zero length opens a one-byte frame
        if (fl == '0)
        begin
            fl = FlBits'(1);
        end
        fr        = first ? 16'd0 : frag_left_reg;
        lf        = first ? 1'b0 : later_reg;
        type_next = first ? in_data.data_type : type_reg;
        ts_next   = first ? in_data.frame_timestamp : ts_reg;

        mtu      = (max_payload == 16'd0) ? 16'd1 : max_payload;
        last     = (fl <= FlBits'(mtu));
        len      = last ? fl[15:0] : mtu;
        need_hdr = (fr == 16'd0);
        if (lf)
        begin
            ft = last ? FtEnd : FtCont;
        end
        else
        begin
            ft = last ? FtWhole : FtStart;
        end
        fr_new = need_hdr ? len : fr;

        fl_dec          = fl - 1'b1;
        frame_left_next = fl_dec;
        frag_left_next  = (fl_dec == '0) ? 16'd0 : fr_new - 1'b1;
        later_next      = lf || need_hdr;

        push_data.data_byte  = in_data.data_byte;
        push_data.need_hdr   = need_hdr;
        push_data.frag_type  = ft;
        push_data.data_type  = type_next;
        push_data.frag_len   = len;
        push_data.packet_end = (fr_new == 16'd1);
        push_data.timestamp  = ts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_left_reg <= '0;
            frag_left_reg  <= '0;
            later_reg      <= 1'b0;
            type_reg       <= '0;
            ts_reg         <= '0;
        end
        else if (push)
        begin
            frame_left_reg <= frame_left_next;
            frag_left_reg  <= frag_left_next;
            later_reg      <= later_next;
            type_reg       <= type_next;
            ts_reg         <= ts_next;
        end
    end

endmodule

### design/vff_back.sv
module vff_back (
    input  logic              clk,
    input  logic              rst_n,
    input  vff_pkg::cmd_t     head,
    input  logic              head_valid,
    output logic              pop,
    input  logic [23:0]       stream_ident,
    output logic              out_valid,
    input  logic              out_ready,
    output vff_pkg::out_item_t out_data
);
    import vff_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_reg;
    out_item_t   out_next;
    logic        load;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            case (state_reg)
                BK_HEAD0: state_next = head.need_hdr ? BK_HEAD1 : BK_HEAD0;
                BK_HEAD1: state_next = BK_HEAD2;
                BK_HEAD2: state_next = BK_HEAD3;
                BK_HEAD3: state_next = BK_HEAD4;
                BK_HEAD4: state_next = BK_HEAD5;
                BK_HEAD5: state_next = BK_DATA;
                BK_DATA:  state_next = BK_HEAD0;
                default:  state_next = BK_HEAD0;
            endcase
        end
    end

    always_comb
    begin
        out_next.packet_timestamp = head.timestamp;
        out_next.is_header        = 1'b1;
        out_next.packet_end       = 1'b0;
        out_next.run_last         = 1'b0;
        out_next.out_byte         = head.data_byte;
        pop                       = 1'b0;
        case (state_reg)
            BK_HEAD0:
            begin
                if (head.need_hdr)
                begin
                    out_next.out_byte = stream_ident[23:16];
                end
                else
                begin
                    out_next.is_header  = 1'b0;
                    out_next.packet_end = head.packet_end;
                    out_next.run_last   = 1'b1;
                    pop                 = load;
                end
            end
            BK_HEAD1: out_next.out_byte = stream_ident[15:8];
            BK_HEAD2: out_next.out_byte = stream_ident[7:0];
            BK_HEAD3: out_next.out_byte = {head.frag_type, head.data_type, PacketCount};
            BK_HEAD4: out_next.out_byte = head.frag_len[15:8];
            BK_HEAD5: out_next.out_byte = head.frag_len[7:0];
            default:
            begin
                out_next.is_header  = 1'b0;
                out_next.packet_end = head.packet_end;
                out_next.run_last   = 1'b1;
                pop                 = load;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_HEAD0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    a_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_HEAD0) |-> head_valid)
        else $error("queue entry lost during a header");

    a_pop_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == BK_DATA || (state_reg == BK_HEAD0 && !head.need_hdr)))
        else $error("entry popped before its payload word");

    a_header_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (load && state_reg == BK_HEAD5) |=> (state_reg == BK_DATA && out_reg.is_header))
        else $error("header did not lead into payload");

endmodule

### bench/video_frame_fragmenter_core_tb.sv
`timescale 1ns / 1ps

module video_frame_fragmenter_core_tb;
    import vff_pkg::*;

    localparam int StallLimit  = 2000;
    localparam int SettleWait  = 12;
    localparam int IdlePercent = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = CfgMaxPayload;
    logic [23:0] cfg_data = '0;

    // Shadow of the block: registers and open-frame state
    logic [15:0] mtu_reg        = MaxPayloadReset;
    logic [23:0] ident_reg      = StreamIdentReset;
    logic [23:0] frame_left     = '0;
    logic [15:0] fragment_left  = '0;
    logic        later_fragment = 1'b0;
    logic [1:0]  held_type      = '0;
    logic [31:0] held_timestamp = '0;

    out_item_t expected_words[$];
    out_item_t oldest_word;
    int        errors      = 0;
    int        idle_cycles = 0;
    bit        steady      = 1'b0;

    video_frame_fragmenter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void push_word(input logic [7:0] b, input logic hdr,
                                      input logic pend, input logic run_end);
        out_item_t w;
        w.out_byte         = b;
        w.is_header        = hdr;
        w.packet_end       = pend;
        w.packet_timestamp = held_timestamp;
        w.run_last         = run_end;
        expected_words.push_back(w);
    endfunction

    // Expected output words for one accepted input byte
    function automatic void fragment_byte(input in_item_t item);
        logic [15:0] mtu;
        logic        is_last;
        logic [15:0] len;
        logic [1:0]  ft;
        logic [31:0] hword;
        if (frame_left == '0)
        begin
            frame_left     = (item.frame_length == '0) ? 24'd1 : item.frame_length;
            held_type      = item.data_type;
            held_timestamp = item.frame_timestamp;
            later_fragment = 1'b0;
            fragment_left  = '0;
        end
        if (fragment_left == '0)
        begin
            mtu     = (mtu_reg == '0) ? 16'd1 : mtu_reg;
            is_last = frame_left <= {8'd0, mtu};
            len     = is_last ? frame_left[15:0] : mtu;
            if (later_fragment)
                ft = is_last ? FtEnd : FtCont;
            else
                ft = is_last ? FtWhole : FtStart;
            hword = {ident_reg, ft, held_type, PacketCount};
            push_word(hword[31:24], 1'b1, 1'b0, 1'b0);
            push_word(hword[23:16], 1'b1, 1'b0, 1'b0);
            push_word(hword[15:8],  1'b1, 1'b0, 1'b0);
            push_word(hword[7:0],   1'b1, 1'b0, 1'b0);
            push_word(len[15:8],    1'b1, 1'b0, 1'b0);
            push_word(len[7:0],     1'b1, 1'b0, 1'b0);
            fragment_left  = len;
            later_fragment = 1'b1;
        end
        push_word(item.data_byte, 1'b0, fragment_left == 16'd1, 1'b1);
        fragment_left = fragment_left - 16'd1;
        frame_left    = frame_left - 24'd1;
        if (frame_left == '0)
            fragment_left = '0;
    endfunction

    function automatic in_item_t make_item(input logic [7:0] b, input logic [23:0] len,
                                           input logic [1:0] dt, input logic [31:0] ts);
        in_item_t item;
        item.data_byte       = b;
        item.frame_length    = len;
        item.data_type       = dt;
        item.frame_timestamp = ts;
        return item;
    endfunction

    function automatic logic [23:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return 24'd0;
            1, 2:    return 24'($urandom_range(25, 60));
            default: return 24'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] pick_mtu();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2, 3:    return 16'($urandom_range(9, 30));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic in_item_t random_item();
        return make_item(8'($urandom), pick_length(), 2'($urandom), $urandom());
    endfunction

    // Offer one input word, idling at random first; predict on acceptance
    task automatic send_byte(input in_item_t item);
        while (!steady && $urandom_range(0, 99) < IdlePercent)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        fragment_byte(item);
    endtask

    // Hold input until every expected word has left, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SettleWait) @(posedge clk);
    endtask

    // Write both registers back to back; upper bits of the mtu word are noise
    task automatic set_config(input logic [15:0] mtu, input logic [23:0] ident);
        cfg_valid <= 1'b1;
        cfg_index <= CfgMaxPayload;
        cfg_data  <= {8'($urandom), mtu};
        do @(posedge clk); while (!cfg_ready);
        mtu_reg = mtu;
        cfg_index <= CfgStreamIdent;
        cfg_data  <= ident;
        do @(posedge clk); while (!cfg_ready);
        ident_reg = ident;
        cfg_valid <= 1'b0;
    endtask

    task automatic close_frame();
        while (frame_left != '0)
            send_byte(random_item());
    endtask

    task automatic test_reset_defaults();
        send_byte(make_item(8'h00, 24'd2, 2'd1, $urandom()));
        send_byte(make_item(8'h5a, 24'd0, 2'd0, 32'd0));
    endtask

    task automatic test_fragment_types();
        settle();
        set_config(16'd1, 24'h000000);
        send_byte(make_item(8'h11, 24'd3, 2'd2, $urandom()));
        send_byte(make_item(8'h22, 24'd0, 2'd0, 32'd0));
        send_byte(make_item(8'h33, 24'd0, 2'd0, 32'd0));
        // zero mtu acts as one, zero length as a single byte
        settle();
        set_config(16'd0, 24'h123456);
        send_byte(make_item(8'ha5, 24'd0, 2'd0, 32'd0));
        send_byte(make_item(8'h5a, 24'd2, 2'd3, $urandom()));
        send_byte(make_item(8'h3c, 24'd7, 2'd1, 32'd0));
    endtask

    task automatic test_extremes();
        settle();
        set_config(16'hffff, 24'hffffff);
        send_byte(make_item(8'hff, 24'd1, 2'd3, 32'hffffffff));
        send_byte(make_item(8'h00, 24'd1, 2'd0, 32'h00000000));
    endtask

    task automatic test_exact_multiple();
        settle();
        set_config(16'd2, 24'($urandom));
        send_byte(make_item(8'h01, 24'd4, 2'd1, $urandom()));
        send_byte(make_item(8'h02, 24'd0, 2'd0, 32'd0));
        send_byte(make_item(8'h03, 24'd0, 2'd0, 32'd0));
        send_byte(make_item(8'h04, 24'd0, 2'd0, 32'd0));
    endtask

    task automatic test_midpacket_resize();
        settle();
        set_config(16'd3, 24'h0f0f0f);
        send_byte(make_item(8'h10, 24'd5, 2'd2, $urandom()));
        settle();
        set_config(16'd1, 24'hf0f0f0);
        for (int i = 0; i < 4; i++)
            send_byte(random_item());
    endtask

    task automatic test_random_frames();
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            set_config(pick_mtu(), 24'($urandom));
            steady = (phase == 4) || (phase == 5);
            for (int i = 0; i < 26; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    settle();
                send_byte(random_item());
            end
        end
        steady = 1'b0;
    endtask

    // Largest frame length; the frame stays open at the end of the run
    task automatic test_open_frame();
        close_frame();
        settle();
        set_config(16'd5, 24'($urandom));
        send_byte(make_item(8'($urandom), 24'hffffff, 2'($urandom), $urandom()));
        for (int i = 1; i < 12; i++)
            send_byte(random_item());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %0h", out_data.out_byte);
                errors++;
            end
            else
            begin
                oldest_word = expected_words.pop_front();
                if (out_data.out_byte !== oldest_word.out_byte)
                begin
                    $error("out_byte: expected %0h, actual %0h",
                           oldest_word.out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.is_header !== oldest_word.is_header)
                begin
                    $error("is_header: expected %0b, actual %0b",
                           oldest_word.is_header, out_data.is_header);
                    errors++;
                end
                if (out_data.packet_end !== oldest_word.packet_end)
                begin
                    $error("packet_end: expected %0b, actual %0b",
                           oldest_word.packet_end, out_data.packet_end);
                    errors++;
                end
                if (out_data.packet_timestamp !== oldest_word.packet_timestamp)
                begin
                    $error("packet_timestamp: expected %0h, actual %0h",
                           oldest_word.packet_timestamp, out_data.packet_timestamp);
                    errors++;
                end
                if (out_data.run_last !== oldest_word.run_last)
                begin
                    $error("run_last: expected %0b, actual %0b",
                           oldest_word.run_last, out_data.run_last);
                    errors++;
                end
            end
        end
        out_ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_fragment_types();
        test_extremes();
        test_exact_multiple();
        test_midpacket_resize();
        test_random_frames();
        test_open_frame();
        settle();
        if (errors == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### video_frame_fragmenter_core.f
design/vff_pkg.sv
design/vff_queue.sv
design/vff_front.sv
design/vff_back.sv
design/video_frame_fragmenter_core.sv
bench/video_frame_fragmenter_core_tb.sv
